// File: rtl/bti_pkg.sv
package bti_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int MAX_BREAKS_DEF  = 64;
  localparam int FRAC_BITS       = 16;
  localparam int QUEUE_DEPTH     = 2;
  // Horner accumulator width, covers |c1|+|c2|+|c3|+2|f| for 32-bit samples
  localparam int ACC_W           = 40;
  // stencil start, wide enough for any break count up to 256
  localparam int FL_W            = 10;
  localparam int CFG_IDX_W       = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BREAKS_DIM0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BREAKS_DIM1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIM0      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIM1      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_DIM0 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_DIM1 = 3'd5;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {MODE_LEFT, MODE_CENTRE, MODE_RIGHT} mode_t;

  typedef enum logic [2:0] {F_IDLE, F_MUL0, F_MUL1, F_CLS1, F_PUSH} front_state_t;

  typedef enum logic {B_IDLE, B_RUN} back_state_t;

  typedef struct packed {
    logic                    action;
    logic [11:0]             addr;
    logic [31:0]             value;
    logic signed [FL_W-1:0]  fl0;
    logic signed [FL_W-1:0]  fl1;
    logic [FRAC_BITS-1:0]    t0;
    logic [FRAC_BITS-1:0]    t1;
    mode_t                   m0;
    mode_t                   m1;
  } item_t;

endpackage

// File: rtl/bti_ram.sv
module bti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/bti_front.sv
module bti_front #(
  parameter int MAX_BREAKS = bti_pkg::MAX_BREAKS_DEF,
  localparam int NBW = $clog2(MAX_BREAKS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [11:0]           in_addr,
  input  logic [31:0]           in_value,
  input  logic signed [31:0]    in_x0,
  input  logic signed [31:0]    in_x1,
  input  logic [NBW-1:0]        nb0,
  input  logic [NBW-1:0]        nb1,
  input  logic signed [31:0]    min0,
  input  logic signed [31:0]    min1,
  input  logic [30:0]           inv0,
  input  logic [30:0]           inv1,
  output logic                  push,
  input  logic                  full,
  output bti_pkg::item_t        item
);

  typedef struct packed {
    logic signed [bti_pkg::FL_W-1:0] fl;
    logic [bti_pkg::FRAC_BITS-1:0]   t;
    bti_pkg::mode_t                  m;
  } cls_t;

  bti_pkg::front_state_t st_r, st_nxt;
  bti_pkg::item_t        item_r;
  logic signed [31:0]    x0_r, x1_r;
  logic [63:0]           p_r;
  cls_t                  cls;

  // (x - min) * inv_step, 32 fraction bits, exact in 64 bits
  function automatic logic [63:0] scale(input logic signed [31:0] x,
                                        input logic signed [31:0] m,
                                        input logic [30:0] inv);
    logic signed [32:0] dx;
    logic signed [64:0] pr;
    dx = 33'(x) - 33'(m);
    pr = dx * $signed({1'b0, inv});
    return pr[63:0];
  endfunction

  function automatic cls_t classify(input logic [63:0] p, input logic [NBW-1:0] nb);
    logic signed [33:0] fl;
    logic signed [33:0] nbs;
    cls_t               r;
    fl  = $signed({{2{p[63]}}, p[63 -: 32]}) - 34'sd1;
    nbs = $signed(34'(nb));
    r.t = p[2*bti_pkg::FRAC_BITS-1 -: bti_pkg::FRAC_BITS];
    r.m = bti_pkg::MODE_CENTRE;
    if (fl < 34'sd0) begin
      r.m = bti_pkg::MODE_LEFT;
    end
    if (fl + 34'sd3 >= nbs) begin
      r.m = bti_pkg::MODE_RIGHT;
    end
    if (fl < -34'sd1) begin
      fl  = -34'sd1;
      r.t = '0;
    end
    if (fl > nbs - 34'sd2) begin
      fl  = nbs - 34'sd2;
      r.t = '0;
    end
    r.fl = bti_pkg::FL_W'(fl);
    return r;
  endfunction

  assign cls = classify(p_r, (st_r == bti_pkg::F_MUL1) ? nb0 : nb1);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bti_pkg::F_IDLE: begin
        if (in_valid) begin
          st_nxt = (in_action == bti_pkg::ACT_QUERY) ? bti_pkg::F_MUL0 : bti_pkg::F_PUSH;
        end
      end
      bti_pkg::F_MUL0: st_nxt = bti_pkg::F_MUL1;
      bti_pkg::F_MUL1: st_nxt = bti_pkg::F_CLS1;
      bti_pkg::F_CLS1: st_nxt = bti_pkg::F_PUSH;
      bti_pkg::F_PUSH: begin
        if (!full) begin
          st_nxt = bti_pkg::F_IDLE;
        end
      end
      default: st_nxt = bti_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (st_r == bti_pkg::F_IDLE);
    push     = (st_r == bti_pkg::F_PUSH) && !full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bti_pkg::F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      bti_pkg::F_IDLE: begin
        if (in_valid) begin
          item_r.action <= in_action;
          item_r.addr   <= in_addr;
          item_r.value  <= in_value;
          x0_r          <= in_x0;
          x1_r          <= in_x1;
        end
      end
      bti_pkg::F_MUL0: p_r <= scale(x0_r, min0, inv0);
      bti_pkg::F_MUL1: begin
        item_r.fl0 <= cls.fl;
        item_r.t0  <= cls.t;
        item_r.m0  <= cls.m;
        p_r        <= scale(x1_r, min1, inv1);
      end
      bti_pkg::F_CLS1: begin
        item_r.fl1 <= cls.fl;
        item_r.t1  <= cls.t;
        item_r.m1  <= cls.m;
      end
      default: begin
      end
    endcase
  end

  assign item = item_r;

endmodule

// File: rtl/bti_queue.sv
module bti_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bti_pkg::item_t din,
  output logic           full,
  input  logic           pop,
  output bti_pkg::item_t dout,
  output logic           valid
);

  localparam int PW = $clog2(bti_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(bti_pkg::QUEUE_DEPTH + 1);

  bti_pkg::item_t mem_r [bti_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [CW-1:0]  cnt_r;

  assign full  = (cnt_r == CW'(bti_pkg::QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  // depth is a power of two, pointers wrap on their own
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// File: rtl/bti_back.sv
module bti_back #(
  parameter int TABLE_DEPTH = bti_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_BREAKS  = bti_pkg::MAX_BREAKS_DEF,
  localparam int NBW = $clog2(MAX_BREAKS + 1),
  localparam int AW  = $clog2(TABLE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  bti_pkg::item_t        q_item,
  output logic                  pop,
  input  logic [NBW-1:0]        nb0,
  input  logic [NBW-1:0]        nb1,
  output logic                  ram_we,
  output logic                  ram_re,
  output logic [AW-1:0]         ram_addr,
  output logic [31:0]           ram_wdata,
  input  logic [31:0]           ram_rdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_data
);

  localparam int IW = bti_pkg::FL_W + 1;
  localparam int LW = 2 * NBW + 2;
  localparam int AC = bti_pkg::ACC_W;
  localparam int PRW = AC + bti_pkg::FRAC_BITS + 1;

  bti_pkg::back_state_t st_r, st_nxt;

  logic signed [bti_pkg::FL_W-1:0] fl0_r, fl1_r;
  logic [bti_pkg::FRAC_BITS-1:0]   t0_r, t1_r, tt_r;
  bti_pkg::mode_t                  m0_r, m1_r;
  logic [4:0]                      fc_r, ld_r;
  logic                            rv_r, ir_r;
  logic [3:0]                      ti_r;
  logic signed [31:0]              taps_r [16];
  logic signed [31:0]              rows_r [4];
  logic                            cb_r;
  logic [1:0]                      cs_r;
  logic [2:0]                      cr_r;
  logic signed [AC-1:0]            acc_r, c2_r, c1_r, f2_r;
  logic                            out_valid_r;
  logic [31:0]                     out_data_r;

  logic                 issue, in_rng, wr_rng, final_row, start, finish, done, out_free;
  logic signed [IW-1:0] i0, i1;
  logic [LW-1:0]        lin;
  logic [31:0]          lin32, wa32;
  logic signed [AC-1:0] fe [4];
  logic signed [AC-1:0] c1, c2, c3, addend, acc_step;
  logic signed [PRW-1:0] prod;
  logic signed [AC-1:0] half;
  logic signed [31:0]   res;
  bti_pkg::mode_t       msel;

  function automatic logic signed [31:0] sat32(input logic signed [AC-1:0] v);
    if (v > $signed(AC'(32'h7fffffff))) begin
      return 32'sh7fffffff;
    end else if (v < -$signed(AC'(33'h080000000))) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // stencil fetch address
  always_comb begin
    issue = (st_r == bti_pkg::B_RUN) && !fc_r[4];
    i0 = IW'(fl0_r) + IW'($signed({1'b0, fc_r[1:0]}));
    i1 = IW'(fl1_r) + IW'($signed({1'b0, fc_r[3:2]}));
    lin = LW'(i0[NBW-1:0]) + LW'(nb0) * LW'(i1[NBW-1:0]);
    lin32 = 32'(lin);
    in_rng = !i0[IW-1] && (i0 < $signed(IW'(nb0))) &&
             !i1[IW-1] && (i1 < $signed(IW'(nb1))) &&
             (lin32 < TABLE_DEPTH);
    wa32 = 32'(q_item.addr);
    wr_rng = (wa32 < TABLE_DEPTH);
  end

  // curve unit operand select and coefficients
  always_comb begin
    final_row = cr_r[2];
    for (int k = 0; k < 4; k++) begin
      fe[k] = final_row ? AC'(rows_r[k]) : AC'(taps_r[{cr_r[1:0], 2'(k)}]);
    end
    msel = final_row ? m1_r : m0_r;
    unique case (msel)
      bti_pkg::MODE_LEFT: begin
        c1 = -(fe[1] * 3) + fe[2] * 4 - fe[3];
        c2 = fe[1] - fe[2] * 2 + fe[3];
        c3 = '0;
      end
      bti_pkg::MODE_RIGHT: begin
        c1 = fe[2] - fe[0];
        c2 = fe[0] - fe[1] * 2 + fe[2];
        c3 = '0;
      end
      default: begin
        c1 = fe[2] - fe[0];
        c2 = fe[0] * 2 - fe[1] * 5 + fe[2] * 4 - fe[3];
        c3 = -fe[0] + fe[1] * 3 - fe[2] * 3 + fe[3];
      end
    endcase
    start = (st_r == bti_pkg::B_RUN) && !cb_r &&
            (final_row || (ld_r >= {3'({1'b0, cr_r[1:0]} + 3'd1), 2'b00}));
    unique case (cs_r)
      2'd0:    addend = c2_r;
      2'd1:    addend = c1_r;
      default: addend = f2_r;
    endcase
    prod     = acc_r * $signed({1'b0, tt_r});
    acc_step = AC'(prod >>> bti_pkg::FRAC_BITS) + addend;
    half     = acc_r >>> 1;
    res      = sat32(half);
    out_free = !out_valid_r || out_ready;
    finish   = cb_r && (cs_r == 2'd3) && (!final_row || out_free);
    done     = finish && final_row;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bti_pkg::B_IDLE: begin
        if (q_valid && q_item.action == bti_pkg::ACT_QUERY) begin
          st_nxt = bti_pkg::B_RUN;
        end
      end
      bti_pkg::B_RUN: begin
        if (done) begin
          st_nxt = bti_pkg::B_IDLE;
        end
      end
      default: st_nxt = bti_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop       = (st_r == bti_pkg::B_IDLE) && q_valid;
    ram_we    = pop && (q_item.action == bti_pkg::ACT_WRITE) && wr_rng;
    ram_re    = issue;
    ram_addr  = ram_we ? wa32[AW-1:0] : lin32[AW-1:0];
    ram_wdata = q_item.value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= bti_pkg::B_IDLE;
      fc_r        <= '0;
      ld_r        <= '0;
      rv_r        <= 1'b0;
      cb_r        <= 1'b0;
      cs_r        <= '0;
      cr_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (pop && q_item.action == bti_pkg::ACT_QUERY) begin
        fc_r <= '0;
        ld_r <= '0;
        rv_r <= 1'b0;
        cb_r <= 1'b0;
        cs_r <= '0;
        cr_r <= '0;
      end else begin
        rv_r <= issue;
        if (issue) begin
          fc_r <= fc_r + 5'd1;
        end
        if (rv_r) begin
          ld_r <= ld_r + 5'd1;
        end
        if (start) begin
          cb_r <= 1'b1;
          cs_r <= '0;
        end else if (finish) begin
          cb_r <= 1'b0;
          if (!final_row) begin
            cr_r <= cr_r + 3'd1;
          end
        end else if (cb_r && cs_r != 2'd3) begin
          cs_r <= cs_r + 2'd1;
        end
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      fl0_r <= q_item.fl0;
      fl1_r <= q_item.fl1;
      t0_r  <= q_item.t0;
      t1_r  <= q_item.t1;
      m0_r  <= q_item.m0;
      m1_r  <= q_item.m1;
    end
    if (issue) begin
      ti_r <= fc_r[3:0];
      ir_r <= in_rng;
    end
    if (rv_r) begin
      taps_r[ti_r] <= ir_r ? $signed(ram_rdata) : 32'sd0;
    end
    if (start) begin
      acc_r <= c3;
      c2_r  <= c2;
      c1_r  <= c1;
      f2_r  <= fe[1] * 2;
      tt_r  <= final_row ? t1_r : t0_r;
    end else if (cb_r && cs_r != 2'd3) begin
      acc_r <= acc_step;
    end
    if (finish && !final_row) begin
      rows_r[cr_r[1:0]] <= res;
    end
    if (done) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/bicubic_table_interpolator.sv
// Path: a sample write reaches the table through the front and the queue; a query result
//   passes the front, the queue and the back (stencil reads, then curves) to the output.
// Flow: the front takes a new transaction only after it pushed the last; the back pops no new
//   item until the shared curve unit is done (5 curves, first after 4 of 16 stencil reads).
// Reset (rst_n low, synchronous): control, queue and output valid clear; the config registers
//   take their defaults. The sample table is not cleared and is undefined until written.
module bicubic_table_interpolator #(
  parameter int TABLE_DEPTH = bti_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_BREAKS  = bti_pkg::MAX_BREAKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // slave side
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [0] action
  input  logic                            in_tuser,
  // [11:0] table_address, [43:12] table_value, [75:44] query_x0, [107:76] query_x1
  input  logic [111:0]                    in_tdata,
  // master side
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] interp_value
  output logic [31:0]                     out_tdata,
  // config write port
  input  logic                            cfg_we,
  input  logic [bti_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [31:0]                     cfg_wdata
);

  localparam int NBW = $clog2(MAX_BREAKS + 1);
  localparam int AW  = $clog2(TABLE_DEPTH);

  // config registers
  logic [6:0]         breaks0_r, breaks1_r;
  logic signed [31:0] min0_r, min1_r;
  logic [30:0]        inv0_r, inv1_r;
  logic [NBW-1:0]     nb0, nb1;

  // front -> queue -> back
  logic           q_push, q_full, q_pop, q_valid;
  bti_pkg::item_t f_item, q_item;

  // table port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_wdata, ram_rdata;

  // break counts above the table limit act as the limit
  function automatic logic [NBW-1:0] eff_breaks(input logic [6:0] b);
    logic [31:0] b32;
    b32 = 32'(b);
    return (b32 > MAX_BREAKS) ? NBW'(MAX_BREAKS) : NBW'(b);
  endfunction

  assign nb0 = eff_breaks(breaks0_r);
  assign nb1 = eff_breaks(breaks1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      breaks0_r <= 7'd40;
      breaks1_r <= 7'd40;
      min0_r    <= 32'sd65536;
      min1_r    <= 32'sd65536;
      inv0_r    <= 31'd638976;
      inv1_r    <= 31'd638976;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bti_pkg::CFG_BREAKS_DIM0:   breaks0_r <= cfg_wdata[6:0];
        bti_pkg::CFG_BREAKS_DIM1:   breaks1_r <= cfg_wdata[6:0];
        bti_pkg::CFG_MIN_DIM0:      min0_r    <= $signed(cfg_wdata);
        bti_pkg::CFG_MIN_DIM1:      min1_r    <= $signed(cfg_wdata);
        bti_pkg::CFG_INV_STEP_DIM0: inv0_r    <= cfg_wdata[30:0];
        bti_pkg::CFG_INV_STEP_DIM1: inv1_r    <= cfg_wdata[30:0];
        default: begin
          // unknown index: dropped
        end
      endcase
    end
  end

  // Front: takes transactions; for a query it scales both coordinates and classifies the stencil.
  bti_front #(
    .MAX_BREAKS(MAX_BREAKS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_action(in_tuser),
    .in_addr  (in_tdata[11:0]),
    .in_value (in_tdata[43:12]),
    .in_x0    ($signed(in_tdata[75:44])),
    .in_x1    ($signed(in_tdata[107:76])),
    .nb0      (nb0),
    .nb1      (nb1),
    .min0     (min0_r),
    .min1     (min1_r),
    .inv0     (inv0_r),
    .inv1     (inv1_r),
    .push     (q_push),
    .full     (q_full),
    .item     (f_item)
  );

  // Short queue keeps writes and queries in order and decouples the two halves.
  bti_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .din  (f_item),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_item),
    .valid(q_valid)
  );

  // Back: table writes, 16 stencil reads, row curves then the column curve.
  bti_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_BREAKS (MAX_BREAKS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (q_pop),
    .nb0      (nb0),
    .nb1      (nb1),
    .ram_we   (ram_we),
    .ram_re   (ram_re),
    .ram_addr (ram_addr),
    .ram_wdata(ram_wdata),
    .ram_rdata(ram_rdata),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_tdata)
  );

  bti_ram #(
    .WIDTH(32),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // single port: a write never lands while a stencil read is in flight
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("table write during stencil read");

  // front must hold off when the queue is full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("queue overflow");

  // a queue entry is only taken when one is there
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue underflow");

endmodule
